// File: src/chroma_rotate_gain_clamp_core_macros.svh
`ifndef CHROMA_ROTATE_GAIN_CLAMP_CORE_MACROS_SVH
`define CHROMA_ROTATE_GAIN_CLAMP_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crg assertion failed");

// next-cycle implication, checked outside reset
`define CRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crg assertion failed");

`endif

// File: src/crg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crg_pkg;

  localparam int SAMPLE_W = 8;
  localparam int CENTER_W = 12;
  localparam int GAIN_W   = 16;
  localparam int ANGLE_W  = 16;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  typedef enum logic [2:0] {
    REG_CENTER_U   = 3'd0,
    REG_CENTER_V   = 3'd1,
    REG_GAIN_U     = 3'd2,
    REG_GAIN_V     = 3'd3,
    REG_COS_ANGLE  = 3'd4,
    REG_SIN_ANGLE  = 3'd5,
    REG_CLAMP_LOW  = 3'd6,
    REG_CLAMP_HIGH = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [CENTER_W-1:0] center_u;
    logic        [CENTER_W-1:0] center_v;
    logic        [GAIN_W-1:0]   gain_u;
    logic        [GAIN_W-1:0]   gain_v;
    logic signed [ANGLE_W-1:0]  cos_angle;
    logic signed [ANGLE_W-1:0]  sin_angle;
    logic        [SAMPLE_W-1:0] clamp_low;
    logic        [SAMPLE_W-1:0] clamp_high;
  } crg_cfg_t;

  localparam crg_cfg_t CFG_RESET = '{
    center_u:   12'd2048,
    center_v:   12'd2048,
    gain_u:     16'd2048,
    gain_v:     16'd2048,
    cos_angle:  16'sd16384,
    sin_angle:  16'sd0,
    clamp_low:  8'd0,
    clamp_high: 8'd255
  };

endpackage

`default_nettype wire

// File: src/crg_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface crg_sample_if;
  logic                          valid;
  logic                          ready;
  logic [crg_pkg::SAMPLE_W-1:0]  u_in;
  logic [crg_pkg::SAMPLE_W-1:0]  v_in;

  modport source (output valid, output u_in, output v_in, input ready);
  modport sink   (input valid, input u_in, input v_in, output ready);
endinterface

`default_nettype wire

// File: src/crg_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface crg_result_if;
  logic                          valid;
  logic                          ready;
  logic [crg_pkg::SAMPLE_W-1:0]  u_out;
  logic [crg_pkg::SAMPLE_W-1:0]  v_out;

  modport source (output valid, output u_out, output v_out, input ready);
  modport sink   (input valid, input u_out, input v_out, output ready);
endinterface

`default_nettype wire

// File: src/chroma_rotate_gain_clamp_core.sv
// Throughput: one word per cycle while the output is not stalled; five register
// stages (center, gain multiply, rotate multiply, accumulate, round and clamp)
// advance together on a free output.
// Reset (rst, synchronous, active high) clears all stage valid bits and loads the
// register defaults: centers 128.0, gains 0.5, angle zero, limits 0 and 255.
`timescale 1ns / 1ps
`default_nettype none

module chroma_rotate_gain_clamp_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  crg_sample_if.sink                       sample,
  crg_result_if.source                     result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [crg_pkg::APB_AW-1:0]  paddr,
  input  wire logic [crg_pkg::APB_DW-1:0]  pwdata,
  output logic      [crg_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import crg_pkg::*;

  crg_cfg_t cfg;

  crg_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crg_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .result (result)
  );

endmodule

`default_nettype wire

// File: src/crg_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module crg_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [crg_pkg::APB_AW-1:0]  paddr,
  input  wire logic [crg_pkg::APB_DW-1:0]  pwdata,
  output logic      [crg_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output crg_pkg::crg_cfg_t                cfg
);
  import crg_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_CENTER_U:   cfg.center_u   <= pwdata[CENTER_W-1:0];
        REG_CENTER_V:   cfg.center_v   <= pwdata[CENTER_W-1:0];
        REG_GAIN_U:     cfg.gain_u     <= pwdata[GAIN_W-1:0];
        REG_GAIN_V:     cfg.gain_v     <= pwdata[GAIN_W-1:0];
        REG_COS_ANGLE:  cfg.cos_angle  <= signed'(pwdata[ANGLE_W-1:0]);
        REG_SIN_ANGLE:  cfg.sin_angle  <= signed'(pwdata[ANGLE_W-1:0]);
        REG_CLAMP_LOW:  cfg.clamp_low  <= pwdata[SAMPLE_W-1:0];
        REG_CLAMP_HIGH: cfg.clamp_high <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CENTER_U:   prdata = {{(APB_DW-CENTER_W){1'b0}}, cfg.center_u};
      REG_CENTER_V:   prdata = {{(APB_DW-CENTER_W){1'b0}}, cfg.center_v};
      REG_GAIN_U:     prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg.gain_u};
      REG_GAIN_V:     prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg.gain_v};
      REG_COS_ANGLE:  prdata = {{(APB_DW-ANGLE_W){1'b0}}, cfg.cos_angle};
      REG_SIN_ANGLE:  prdata = {{(APB_DW-ANGLE_W){1'b0}}, cfg.sin_angle};
      REG_CLAMP_LOW:  prdata = {{(APB_DW-SAMPLE_W){1'b0}}, cfg.clamp_low};
      REG_CLAMP_HIGH: prdata = {{(APB_DW-SAMPLE_W){1'b0}}, cfg.clamp_high};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/crg_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chroma_rotate_gain_clamp_core_macros.svh"

module crg_pipe (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire crg_pkg::crg_cfg_t cfg,
  crg_sample_if.sink             sample,
  crg_result_if.source           result
);
  import crg_pkg::*;

  localparam int STAGES = 5;
  localparam int DIFF_W = CENTER_W + 1;
  localparam int SCL_W  = DIFF_W + GAIN_W + 1;
  localparam int PROD_W = SCL_W + ANGLE_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FRAC   = 30;
  localparam int RES_W  = ACC_W - FRAC;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    (ACC_W'(128) << FRAC) + (ACC_W'(1) << (FRAC - 1));

  function automatic logic [SAMPLE_W-1:0] finish(
    input logic signed [ACC_W-1:0]  acc,
    input logic        [SAMPLE_W-1:0] lo,
    input logic        [SAMPLE_W-1:0] hi
  );
    logic signed [ACC_W-1:0] t;
    logic signed [RES_W-1:0] r;
    t = acc + ROUND_BIAS;
    r = t[ACC_W-1:FRAC];
    if (r < signed'({{(RES_W-SAMPLE_W){1'b0}}, lo})) begin
      return lo;
    end else if (r > signed'({{(RES_W-SAMPLE_W){1'b0}}, hi})) begin
      return hi;
    end else begin
      return r[SAMPLE_W-1:0];
    end
  endfunction

  logic [STAGES-1:0] vld;
  logic              adv;

  logic signed [DIFF_W-1:0] du, dv;
  logic signed [SCL_W-1:0]  su, sv;
  logic signed [PROD_W-1:0] pu_c, pv_s, pv_c, pu_s;
  logic signed [ACC_W-1:0]  au, av;
  logic [SAMPLE_W-1:0]      u_res, v_res;

  assign adv          = !vld[STAGES-1] || result.ready;
  assign sample.ready = adv;
  assign result.valid = vld[STAGES-1];
  assign result.u_out = u_res;
  assign result.v_out = v_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], sample.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      du    <= signed'({1'b0, sample.u_in, 4'b0000}) - signed'({1'b0, cfg.center_u});
      dv    <= signed'({1'b0, sample.v_in, 4'b0000}) - signed'({1'b0, cfg.center_v});
      su    <= du * signed'({1'b0, cfg.gain_u});
      sv    <= dv * signed'({1'b0, cfg.gain_v});
      pu_c  <= su * cfg.cos_angle;
      pv_s  <= sv * cfg.sin_angle;
      pv_c  <= sv * cfg.cos_angle;
      pu_s  <= su * cfg.sin_angle;
      au    <= ACC_W'(pu_c) - ACC_W'(pv_s);
      av    <= ACC_W'(pv_c) + ACC_W'(pu_s);
      u_res <= finish(au, cfg.clamp_low, cfg.clamp_high);
      v_res <= finish(av, cfg.clamp_low, cfg.clamp_high);
    end
  end

  `CRG_ASSERT_NEXT(a_stall_holds_valids, clk, rst, !adv, $stable(vld))
  `CRG_ASSERT_NEXT(a_last_stage_fill, clk, rst, adv && vld[STAGES-2], vld[STAGES-1])
  `CRG_ASSERT_IMPLY(a_u_in_limits, clk, rst,
    result.valid && (cfg.clamp_low <= cfg.clamp_high),
    (result.u_out >= cfg.clamp_low) && (result.u_out <= cfg.clamp_high))
  `CRG_ASSERT_IMPLY(a_v_in_limits, clk, rst,
    result.valid && (cfg.clamp_low <= cfg.clamp_high),
    (result.v_out >= cfg.clamp_low) && (result.v_out <= cfg.clamp_high))

endmodule

`default_nettype wire
